// ===== design/scpd_pkg.sv =====
// Shared types and constants for the serial-commanded PWM dimmer.
// Used by every module in the design folder; depends on nothing.
package scpd_pkg;

    localparam int DUTY_W   = 7;
    localparam int PERIOD_W = 16;
    localparam int CMP_W    = 16;
    localparam int PROD_W   = PERIOD_W + DUTY_W;
    localparam int QUART_W  = PROD_W - 2;
    localparam int RECIP_W  = 22;
    localparam int RECIP_SH = 26;

    // ceil(2^26 / 25); exact for any dividend below 2^21.
    localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

    localparam logic [DUTY_W-1:0] DUTY_TOP  = 7'd99;
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 7'd0;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic RAMP_TRIANGLE = 1'b0;
    localparam logic RAMP_TARGET   = 1'b1;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_MARK = 8'h24;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [7:0] WORD_MANUAL [6] = '{8'h6D, 8'h61, 8'h6E, 8'h75, 8'h61, 8'h6C};
    localparam logic [7:0] WORD_AUTO   [4] = '{8'h61, 8'h75, 8'h74, 8'h6F};
    localparam logic [7:0] WORD_PWM    [3] = '{8'h50, 8'h57, 8'h4D};

    typedef struct packed {
        logic              mode;
        logic [DUTY_W-1:0] target;
    } frame_ctrl_t;

endpackage

// ===== design/scpd_frame.sv =====
// Command frame collector and decoder: character store, mode and target.
// Depends on scpd_pkg.
module scpd_frame #(
    parameter int BUFFER_DEPTH = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           rx_byte,
    output scpd_pkg::frame_ctrl_t ctrl,
    output scpd_pkg::frame_ctrl_t ctrl_next
);
    import scpd_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int IW = $clog2(BUFFER_DEPTH);

    logic              open_reg, open_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [7:0]        store_reg [BUFFER_DEPTH];
    frame_ctrl_t       ctrl_reg;

    logic              is_filler;
    logic              is_mark;
    logic              store_we;
    logic              match_manual, match_auto, match_pwm, digits_ok;
    logic [DUTY_W-1:0] tens, ones, target_calc;

    always_comb
    begin
        is_filler = (rx_byte == CHAR_NUL) || (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
        is_mark   = (rx_byte == CHAR_MARK);

        match_manual = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            if (store_reg[i] != WORD_MANUAL[i])
            begin
                match_manual = 1'b0;
            end
        end
        match_auto = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (store_reg[i] != WORD_AUTO[i])
            begin
                match_auto = 1'b0;
            end
        end
        match_pwm = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (store_reg[i] != WORD_PWM[i])
            begin
                match_pwm = 1'b0;
            end
        end
        digits_ok = (store_reg[3] >= CHAR_ZERO) && (store_reg[3] <= CHAR_NINE)
                 && (store_reg[4] >= CHAR_ZERO) && (store_reg[4] <= CHAR_NINE);

        tens        = {3'b000, 4'(store_reg[3] - CHAR_ZERO)};
        ones        = {3'b000, 4'(store_reg[4] - CHAR_ZERO)};
        target_calc = (tens << 3) + (tens << 1) + ones;

        open_next  = open_reg;
        count_next = count_reg;
        ctrl_next  = ctrl_reg;
        store_we   = 1'b0;

        if (take && !is_filler)
        begin
            if (!open_reg)
            begin
                if (is_mark)
                begin
                    open_next  = 1'b1;
                    count_next = '0;
                end
            end
            else if (is_mark)
            begin
                // Closing mark: the first word that matches wins.
                open_next = 1'b0;
                if (match_manual)
                begin
                    ctrl_next.mode = RAMP_TARGET;
                end
                else if (match_auto)
                begin
                    ctrl_next.mode = RAMP_TRIANGLE;
                end
                else if (match_pwm && digits_ok)
                begin
                    ctrl_next.target = target_calc;
                end
            end
            else if (count_reg < CW'(BUFFER_DEPTH))
            begin
                store_we   = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= '0;
            ctrl_reg  <= '{mode: RAMP_TRIANGLE, target: DUTY_ZERO};
            for (int i = 0; i < BUFFER_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            open_reg  <= open_next;
            count_reg <= count_next;
            ctrl_reg  <= ctrl_next;
            if (store_we)
            begin
                store_reg[count_reg[IW-1:0]] <= rx_byte;
            end
        end
    end

    assign ctrl = ctrl_reg;

endmodule

// ===== design/scpd_duty.sv =====
// Duty engine: manual slew toward the target or automatic triangle ramp.
// Depends on scpd_pkg.
module scpd_duty (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  scpd_pkg::frame_ctrl_t        ctrl,
    output logic [scpd_pkg::DUTY_W-1:0]  duty,
    output logic [scpd_pkg::DUTY_W-1:0]  duty_next
);
    import scpd_pkg::*;

    logic              duty_reg;
    logic [DUTY_W-1:0] level_reg;
    logic              down_next;
    logic [DUTY_W-1:0] step;

    always_comb
    begin
        duty_next = level_reg;
        down_next = duty_reg;
        step      = level_reg;
        if (tick)
        begin
            if (ctrl.mode == RAMP_TARGET)
            begin
                if (level_reg < ctrl.target)
                begin
                    duty_next = level_reg + 1'b1;
                end
                else if (level_reg > ctrl.target)
                begin
                    duty_next = level_reg - 1'b1;
                end
            end
            else if (!duty_reg)
            begin
                step      = (level_reg < DUTY_TOP) ? level_reg + 1'b1 : level_reg;
                duty_next = step;
                if (step >= DUTY_TOP)
                begin
                    down_next = 1'b1;
                end
            end
            else
            begin
                step      = (level_reg > DUTY_ZERO) ? level_reg - 1'b1 : level_reg;
                duty_next = step;
                if (step == DUTY_ZERO)
                begin
                    down_next = 1'b0;
                end
            end
        end
    end

    // duty_reg holds the ramp direction: set while falling.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg  <= 1'b0;
            level_reg <= DUTY_ZERO;
        end
        else
        begin
            duty_reg  <= down_next;
            level_reg <= duty_next;
        end
    end

    assign duty = level_reg;

endmodule

// ===== design/scpd_scale.sv =====
// Divide-by-100 of the period-times-duty product by reciprocal multiplication.
// Depends on scpd_pkg.
module scpd_scale (
    input  logic [scpd_pkg::PROD_W-1:0] product,
    output logic [scpd_pkg::CMP_W-1:0]  compare
);
    import scpd_pkg::*;

    logic [QUART_W-1:0]         quarter;
    logic [QUART_W+RECIP_W-1:0] scaled;

    // x / 100 = (x / 4) / 25; the reciprocal of 25 is exact over the quarter's range.
    always_comb
    begin
        quarter = product[PROD_W-1:2];
        scaled  = {{RECIP_W{1'b0}}, quarter} * {{QUART_W{1'b0}}, RECIP_25};
        compare = scaled[RECIP_SH +: CMP_W];
    end

endmodule

// ===== design/serial_commanded_pwm_dimmer_top.sv =====
// Top level of the serial-commanded PWM dimmer.
// Depends on scpd_pkg, scpd_frame, scpd_duty and scpd_scale.
//
// Usage:
//   The item channel (item_valid, item_stall, cmd, rx_byte) carries one beat per
//   received serial character (cmd low) or per PWM update tick (cmd high). The
//   result channel (result_valid, result_stall, duty_now, compare_value, mode_now,
//   target_now) returns exactly one beat per item, in order.
//   The APB port holds one register, period, at byte address 0; it must be written
//   only while no item is in flight.
//   From accepted item to result beat, each item passes an input register,
//   a state update stage that also forms period * duty, and an output stage that
//   divides that product by 100 with a reciprocal multiply. The pipeline takes one
//   item every cycle while the result side does not stall; the state update sets the throughput.
//   When the receiver stalls, stages fill up behind the held result and item_stall
//   rises only once all three stages hold beats.
//   Reset clears the frame state, the character store, mode (automatic), target
//   and duty to zero and sets period to 99.
module serial_commanded_pwm_dimmer_top #(
    parameter int BUFFER_DEPTH = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 cmd,
    input  logic [7:0]                           rx_byte,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [scpd_pkg::DUTY_W-1:0]          duty_now,
    output logic [scpd_pkg::CMP_W-1:0]           compare_value,
    output logic                                 mode_now,
    output logic [scpd_pkg::DUTY_W-1:0]          target_now,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import scpd_pkg::*;

    // Configuration register.
    logic [PERIOD_W-1:0] period_reg;

    // Input stage.
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // Middle stage, holding the state after the item and the raw product.
    logic              mid_valid_reg;
    logic [DUTY_W-1:0] mid_duty_reg;
    logic              mid_mode_reg;
    logic [DUTY_W-1:0] mid_target_reg;
    logic [PROD_W-1:0] mid_prod_reg;

    // Output stage.
    logic              out_valid_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic [CMP_W-1:0]  out_cmp_reg;
    logic              out_mode_reg;
    logic [DUTY_W-1:0] out_target_reg;

    logic out_free, mid_move, mid_free, in_move, in_free, accept;

    frame_ctrl_t       ctrl, ctrl_next;
    logic [DUTY_W-1:0] duty, duty_next;
    logic [CMP_W-1:0]  compare;
    logic              take_char, take_tick;

    // Each stage advances when the stage ahead is empty or moving on.
    always_comb
    begin
        out_free  = !out_valid_reg || !result_stall;
        mid_move  = mid_valid_reg && out_free;
        mid_free  = !mid_valid_reg || mid_move;
        in_move   = in_valid_reg && mid_free;
        in_free   = !in_valid_reg || in_move;
        accept    = item_valid && in_free;
        take_char = in_move && (in_cmd_reg == CMD_CHAR);
        take_tick = in_move && (in_cmd_reg == CMD_TICK);
    end

    assign item_stall = !in_free;

    scpd_frame #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_frame (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take_char),
        .rx_byte  (in_byte_reg),
        .ctrl     (ctrl),
        .ctrl_next(ctrl_next)
    );

    scpd_duty u_duty (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (take_tick),
        .ctrl     (ctrl),
        .duty     (duty),
        .duty_next(duty_next)
    );

    scpd_scale u_scale (
        .product(mid_prod_reg),
        .compare(compare)
    );

    // Control state of the pipeline and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= 16'd99;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= item_valid;
            end
            if (mid_free)
            begin
                mid_valid_reg <= in_move;
            end
            if (out_free)
            begin
                out_valid_reg <= mid_move;
            end
            if (psel && penable && pwrite && pready && !paddr[2])
            begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    // Payload registers, loaded only when their stage takes a beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg  <= cmd;
            in_byte_reg <= rx_byte;
        end
        if (in_move)
        begin
            mid_duty_reg   <= duty_next;
            mid_mode_reg   <= ctrl_next.mode;
            mid_target_reg <= ctrl_next.target;
            mid_prod_reg   <= {{DUTY_W{1'b0}}, period_reg} * {{PERIOD_W{1'b0}}, duty_next};
        end
        if (mid_move)
        begin
            out_duty_reg   <= mid_duty_reg;
            out_cmp_reg    <= compare;
            out_mode_reg   <= mid_mode_reg;
            out_target_reg <= mid_target_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign duty_now      = out_duty_reg;
    assign compare_value = out_cmp_reg;
    assign mode_now      = out_mode_reg;
    assign target_now    = out_target_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - PERIOD_W){1'b0}}, period_reg};

    // The input side only stalls when every stage holds a beat behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_valid_reg && mid_valid_reg && out_valid_reg && result_stall))
        else $error("item_stall raised while the pipeline has room");

    // The duty moves by at most one step per processed item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_move |=> (duty == $past(duty) || duty == $past(duty) + 1'b1
                     || duty == $past(duty) - 1'b1))
        else $error("duty jumped by more than one step");

    // The pulse length never exceeds the period it was scaled from.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (compare_value <= period_reg))
        else $error("compare value above period");

    // A processed item lands in the middle stage on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_move |=> mid_valid_reg)
        else $error("processed beat lost before the middle stage");

endmodule
